// ----- hw/rtl/sensor_median_ema_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sensor median/EMA filter
// Shorthand for clocked implications, with asynchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MEDIAN_EMA_FILTER_ASSERT_SVH
`define SENSOR_MEDIAN_EMA_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SMEF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smef_checker: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SMEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smef_checker: next-cycle check failed");

`endif

// ----- hw/rtl/smef_pkg.sv -----
// ----------------------------------------------------------------------------
// smef_pkg
// Shared widths, constants, register indices and control bundles.
// ----------------------------------------------------------------------------
package smef_pkg;

    // field widths
    localparam int SAMPLE_BITS    = 12;
    localparam int FRAC_BITS      = 16;
    localparam int AVG_W          = SAMPLE_BITS + FRAC_BITS;
    localparam int ALPHA_W        = 17;
    localparam int WCOUNT_W       = 5;
    localparam int CFG_W          = ALPHA_W;
    localparam int CFG_IDX_W      = 3;
    localparam int WINDOW_MAX_DEF = 16;

    // EMA arithmetic widths
    localparam int DIFF_W  = AVG_W + 1;
    localparam int PROD_W  = DIFF_W + ALPHA_W;
    localparam int DELTA_W = PROD_W - FRAC_BITS;
    localparam int SUM_W   = AVG_W + 3;

    localparam logic [SAMPLE_BITS-1:0] CODE_MAX   = '1;
    localparam int unsigned            ROUND_HALF = 1 << (FRAC_BITS - 1);

    // configuration reset values
    localparam logic [WCOUNT_W-1:0]    WCOUNT_RST = WCOUNT_W'(5);
    localparam logic [ALPHA_W-1:0]     ALPHA_RST  = ALPHA_W'(6554);

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_COUNT = 3'd0,
        REG_ALPHA        = 3'd1,
        REG_INVERT       = 3'd2,
        REG_FAULT_LOW    = 3'd3,
        REG_FAULT_HIGH   = 3'd4
    } cfg_reg_t;

    // request to the median unit
    typedef struct packed {
        logic start;
        logic refill;
    } med_req_t;

    // request to the EMA unit
    typedef struct packed {
        logic prime;
        logic start;
    } ema_req_t;

endpackage

// ----- hw/rtl/smef_ram.sv -----
// ----------------------------------------------------------------------------
// smef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smef_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/smef_median.sv -----
// ----------------------------------------------------------------------------
// smef_median
// Ring window store and bit-serial rank selection of the window median.
// ----------------------------------------------------------------------------
module smef_median
    import smef_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  med_req_t                            req,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic [$clog2(WINDOW_MAX + 1)-1:0]   count,
    output logic                                done,
    output logic [SAMPLE_BITS-1:0]              median
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int BIT_W = $clog2(SAMPLE_BITS);

    typedef enum logic [2:0] {
        M_IDLE,
        M_FILL,
        M_WRITE,
        M_SEL,
        M_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [IDX_W-1:0]       fill_idx_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [BIT_W-1:0]       iss_bit_reg;
    logic                   pend_reg;
    logic                   pend_last_reg;
    logic [SAMPLE_BITS-1:0] bit_sel_reg;
    logic [SAMPLE_BITS-1:0] mask_reg;
    logic [SAMPLE_BITS-1:0] res_reg;
    logic [CNT_W-1:0]       rank_reg;
    logic [CNT_W-1:0]       zeros_reg;
    logic                   done_reg;

    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       slot_next;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   hit;
    logic [CNT_W-1:0]       zeros_sum;

    // ring bookkeeping
    assign last_idx  = IDX_W'(count_reg - 1'b1);
    assign slot_next = (slot_reg == last_idx) ? '0 : slot_reg + 1'b1;

    // window writes: refill sweep or single ring write
    assign ram_we    = (state_reg == M_FILL) || (state_reg == M_WRITE);
    assign ram_waddr = (state_reg == M_FILL) ? fill_idx_reg : slot_reg;

    smef_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // entry shares the decided prefix and has a zero at the current bit
    assign hit       = pend_reg && (((ram_rdata ^ res_reg) & mask_reg) == '0)
                       && ((ram_rdata & bit_sel_reg) == '0);
    assign zeros_sum = zeros_reg + CNT_W'(hit);

    // sequencer and selection datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= M_IDLE;
            sample_reg    <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            fill_idx_reg  <= '0;
            rd_idx_reg    <= '0;
            iss_bit_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            bit_sel_reg   <= '0;
            mask_reg      <= '0;
            res_reg       <= '0;
            rank_reg      <= '0;
            zeros_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            pend_reg      <= (state_reg == M_SEL);
            pend_last_reg <= (rd_idx_reg == last_idx);

            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        sample_reg   <= sample;
                        count_reg    <= count;
                        fill_idx_reg <= '0;
                        if (req.refill)
                        begin
                            slot_reg  <= '0;
                            state_reg <= M_FILL;
                        end
                        else
                        begin
                            state_reg <= M_WRITE;
                        end
                    end
                end
                M_FILL:
                begin
                    if (fill_idx_reg == last_idx)
                    begin
                        state_reg <= M_WRITE;
                    end
                    else
                    begin
                        fill_idx_reg <= fill_idx_reg + 1'b1;
                    end
                end
                M_WRITE:
                begin
                    // ring advance, then arm the selection from the top bit
                    slot_reg    <= slot_next;
                    rd_idx_reg  <= '0;
                    iss_bit_reg <= BIT_W'(SAMPLE_BITS - 1);
                    bit_sel_reg <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
                    mask_reg    <= '0;
                    res_reg     <= '0;
                    rank_reg    <= count_reg >> 1;
                    zeros_reg   <= '0;
                    state_reg   <= M_SEL;
                end
                M_SEL:
                begin
                    // one window read per cycle, n reads per result bit
                    if (rd_idx_reg == last_idx)
                    begin
                        rd_idx_reg <= '0;
                        if (iss_bit_reg == '0)
                        begin
                            state_reg <= M_DRAIN;
                        end
                        else
                        begin
                            iss_bit_reg <= iss_bit_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                M_DRAIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase

            // count zeros among candidates; settle one bit per pass
            if (pend_reg)
            begin
                if (pend_last_reg)
                begin
                    if (rank_reg >= zeros_sum)
                    begin
                        res_reg  <= res_reg | bit_sel_reg;
                        rank_reg <= rank_reg - zeros_sum;
                    end
                    mask_reg    <= mask_reg | bit_sel_reg;
                    bit_sel_reg <= bit_sel_reg >> 1;
                    zeros_reg   <= '0;
                end
                else
                begin
                    zeros_reg <= zeros_sum;
                end
            end
        end
    end

    assign done   = done_reg;
    assign median = res_reg;

endmodule

// ----- hw/rtl/smef_ema.sv -----
// ----------------------------------------------------------------------------
// smef_ema
// Exponential moving average with a bit-serial shift-add weight multiply.
// ----------------------------------------------------------------------------
module smef_ema
    import smef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ema_req_t               req,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] median,
    input  logic [ALPHA_W-1:0]     alpha,
    output logic                   done,
    output logic [AVG_W-1:0]       average
);

    localparam int STEP_W = $clog2(ALPHA_W);

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_UPD
    } state_t;

    state_t                     state_reg;
    logic [AVG_W-1:0]           avg_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   mcand_reg;
    logic [ALPHA_W-1:0]         alpha_sh_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       done_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [SUM_W-1:0]    sum;
    logic [AVG_W-1:0]           avg_clamped;

    // error between median and average, signed Q12.16
    assign diff = $signed({1'b0, median, {FRAC_BITS{1'b0}}}) - $signed({1'b0, avg_reg});

    // floor of product / 2^16, then saturate to the average range
    assign delta = $signed(acc_reg[PROD_W-1:FRAC_BITS]);
    assign sum   = $signed({{(SUM_W - AVG_W){1'b0}}, avg_reg})
                   + $signed({{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta});

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            avg_clamped = '0;
        end
        else if (|sum[SUM_W-2:AVG_W])
        begin
            avg_clamped = '1;
        end
        else
        begin
            avg_clamped = sum[AVG_W-1:0];
        end
    end

    // sequencer, multiplier and average register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= E_IDLE;
            avg_reg      <= '0;
            acc_reg      <= '0;
            mcand_reg    <= '0;
            alpha_sh_reg <= '0;
            step_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (req.prime)
                    begin
                        avg_reg <= {sample, {FRAC_BITS{1'b0}}};
                    end
                    if (req.start)
                    begin
                        acc_reg      <= '0;
                        mcand_reg    <= {{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff};
                        alpha_sh_reg <= alpha;
                        step_reg     <= STEP_W'(ALPHA_W - 1);
                        state_reg    <= E_MUL;
                    end
                end
                E_MUL:
                begin
                    // one weight bit per cycle, LSB first
                    if (alpha_sh_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg    <= mcand_reg <<< 1;
                    alpha_sh_reg <= alpha_sh_reg >> 1;
                    if (step_reg == '0)
                    begin
                        state_reg <= E_UPD;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                E_UPD:
                begin
                    avg_reg   <= avg_clamped;
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign average = avg_reg;

endmodule

// ----- hw/rtl/sensor_median_ema_filter.sv -----
// ----------------------------------------------------------------------------
// sensor_median_ema_filter
// Each request carries one 12-bit converter sample. The sample goes into a
// ring window held in a small RAM, the median of the configured window
// (upper middle element for even sizes) is found bit by bit, most
// significant first, reading one window entry per cycle, and drives an
// unsigned Q12.16 moving average whose weight is applied by a bit-serial
// shift-add multiplier. One result follows each request: the rounded
// average, saturated to 4095 and mirrored when invert is set, and a flag
// telling whether it lies within the fault limits. The window is refilled
// with the sample on the first request and on a new window size; the
// selection passes over the RAM read port take most of a request's time.
// One request is in flight at a time; the next is taken while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module sensor_median_ema_filter
    import smef_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // sample channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] position,
    output logic                   plausible
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_MED,
        T_EMA,
        T_EMIT
    } state_t;

    state_t                 state_reg;
    logic [WCOUNT_W-1:0]    window_count_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic                   invert_reg;
    logic [SAMPLE_BITS-1:0] fault_low_reg;
    logic [SAMPLE_BITS-1:0] fault_high_reg;
    logic [CNT_W-1:0]       active_count_reg;
    logic                   primed_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] position_reg;
    logic                   plausible_reg;

    logic                   in_accept;
    logic [CNT_W-1:0]       n;
    med_req_t               med_req;
    ema_req_t               ema_req;
    logic                   med_done;
    logic [SAMPLE_BITS-1:0] med_value;
    logic                   ema_done;
    logic [AVG_W-1:0]       avg;
    logic [AVG_W:0]         rounded;
    logic [SAMPLE_BITS:0]   whole;
    logic [SAMPLE_BITS-1:0] sat;
    logic [SAMPLE_BITS-1:0] pos;
    logic                   out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != T_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // clamp window size to 1..WINDOW_MAX
    always_comb
    begin
        if (window_count_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if ({1'b0, window_count_reg} > (WCOUNT_W + 1)'(WINDOW_MAX))
        begin
            n = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            n = CNT_W'(window_count_reg);
        end
    end

    // requests to the two units
    assign med_req.start  = in_accept;
    assign med_req.refill = !primed_reg || (n != active_count_reg);
    assign ema_req.prime  = in_accept && !primed_reg;
    assign ema_req.start  = (state_reg == T_MED) && med_done;

    smef_median #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (med_req),
        .sample (sample),
        .count  (n),
        .done   (med_done),
        .median (med_value)
    );

    smef_ema u_ema (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ema_req),
        .sample  (sample),
        .median  (med_value),
        .alpha   (alpha_reg),
        .done    (ema_done),
        .average (avg)
    );

    // round, saturate, mirror
    assign rounded = {1'b0, avg} + (AVG_W + 1)'(ROUND_HALF);
    assign whole   = rounded[AVG_W:FRAC_BITS];
    assign sat     = whole[SAMPLE_BITS] ? CODE_MAX : whole[SAMPLE_BITS-1:0];
    assign pos     = invert_reg ? (CODE_MAX - sat) : sat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= WCOUNT_RST;
            alpha_reg        <= ALPHA_RST;
            invert_reg       <= 1'b0;
            fault_low_reg    <= '0;
            fault_high_reg   <= CODE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_COUNT: window_count_reg <= cfg_data[WCOUNT_W-1:0];
                REG_ALPHA:        alpha_reg        <= cfg_data[ALPHA_W-1:0];
                REG_INVERT:       invert_reg       <= cfg_data[0];
                REG_FAULT_LOW:    fault_low_reg    <= cfg_data[SAMPLE_BITS-1:0];
                REG_FAULT_HIGH:   fault_high_reg   <= cfg_data[SAMPLE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // request sequencing and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            active_count_reg <= '0;
            primed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            position_reg     <= '0;
            plausible_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_accept)
                    begin
                        active_count_reg <= n;
                        primed_reg       <= 1'b1;
                        state_reg        <= T_MED;
                    end
                end
                T_MED:
                begin
                    if (med_done)
                    begin
                        state_reg <= T_EMA;
                    end
                end
                T_EMA:
                begin
                    if (ema_done)
                    begin
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        position_reg  <= pos;
                        plausible_reg <= (pos >= fault_low_reg) && (pos <= fault_high_reg);
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign plausible = plausible_reg;

endmodule

// ----- hw/rtl/smef_checker.sv -----
// ----------------------------------------------------------------------------
// smef_checker
// Port-level checks on the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_median_ema_filter_assert.svh"

module smef_checker
    import smef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [SAMPLE_BITS-1:0] position,
    input  logic                   plausible
);

    // an accepted request keeps the input side busy
    `SMEF_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && !in_stall, in_stall)

    // the input side only goes busy because of a request
    `SMEF_ASSERT_SAME(a_busy_needs_request, clk, rst_n, $rose(in_stall), $past(in_valid))

    // a new result is launched from the busy phase, which then ends
    `SMEF_ASSERT_SAME(a_result_ends_work, clk, rst_n, $rose(out_valid), $past(in_stall) && !in_stall)

    // a held result stays put
    `SMEF_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(position) && $stable(plausible))

endmodule

bind sensor_median_ema_filter smef_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .plausible (plausible)
);

// ----- bench/sensor_median_ema_filter_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_median_ema_filter_tb
// Self-checking bench for the median/EMA sensor filter. Samples go in over
// the valid/stall request channel, and a local model of the ring window,
// median selection and Q12.16 moving average predicts each reading. Each
// reading is checked against the oldest prediction. Directed requests cover
// the field extremes, window sizes out of range, alpha at zero, unity and
// above unity, output mirroring and crossed fault limits. Random bursts
// under several register settings follow, with idle gaps on both sides.
// ----------------------------------------------------------------------------
module sensor_median_ema_filter_tb;
    import smef_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [SAMPLE_BITS-1:0] position;
        logic                   plausible;
    } reading_t;

    // DUT connections, all inputs known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample    = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0] position;
    logic                   plausible;

    // idle rates, per cent of cycles
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // filter model: register copies
    logic [WCOUNT_W-1:0]    cfg_count  = WCOUNT_RST;
    logic [ALPHA_W-1:0]     cfg_alpha  = ALPHA_RST;
    logic                   cfg_invert = 1'b0;
    logic [SAMPLE_BITS-1:0] cfg_low    = '0;
    logic [SAMPLE_BITS-1:0] cfg_high   = CODE_MAX;

    // filter model: state
    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX_DEF];
    int unsigned            ring_slot   = 0;
    int unsigned            ring_size   = 0;
    logic [AVG_W-1:0]       avg_q16     = '0;
    logic                   avg_primed  = 1'b0;

    reading_t expected_readings[$];

    sensor_median_ema_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .plausible (plausible)
    );

    always #10 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // fill the used part of the window with one value, restart the ring
    task automatic refill_ring(input logic [SAMPLE_BITS-1:0] s, input int unsigned n);
        for (int i = 0; i < n; i++)
            ring[i] = s;
        ring_slot = 0;
        ring_size = n;
    endtask

    // advance the model by one sample and queue the reading it gives
    task automatic predict_reading(input logic [SAMPLE_BITS-1:0] s);
        int unsigned            n;
        int                     j;
        logic [SAMPLE_BITS-1:0] ranked [WINDOW_MAX_DEF];
        logic [SAMPLE_BITS-1:0] key;
        logic [SAMPLE_BITS-1:0] med;
        longint                 diff;
        longint                 weighted;
        longint                 next_avg;
        int unsigned            level;
        reading_t               r;

        n = (cfg_count == 0) ? 1 : (cfg_count > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : cfg_count;

        if (!avg_primed)
        begin
            refill_ring(s, n);
            avg_q16    = {s, {FRAC_BITS{1'b0}}};
            avg_primed = 1'b1;
        end
        else if (n != ring_size)
            refill_ring(s, n);

        ring[ring_slot] = s;
        ring_slot = (ring_slot + 1) % n;

        // insertion sort of the used entries, upper middle for even n
        ranked = ring;
        for (int i = 1; i < n; i++)
        begin
            key = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > key)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        med = ranked[n/2];

        // EMA step, floor division by 2^16, average held in 0..2^28-1
        diff     = (longint'(med) <<< FRAC_BITS) - longint'(avg_q16);
        weighted = longint'(cfg_alpha) * diff;
        next_avg = longint'(avg_q16) + (weighted >>> FRAC_BITS);
        if (next_avg < 0)
            next_avg = 0;
        if (next_avg > ((longint'(1) <<< AVG_W) - 1))
            next_avg = (longint'(1) <<< AVG_W) - 1;
        avg_q16 = next_avg[AVG_W-1:0];

        level = (int'(avg_q16) + ROUND_HALF) >> FRAC_BITS;
        if (level > CODE_MAX)
            level = CODE_MAX;

        r.position  = cfg_invert ? CODE_MAX - level[SAMPLE_BITS-1:0] : level[SAMPLE_BITS-1:0];
        r.plausible = (r.position >= cfg_low) && (r.position <= cfg_high);
        expected_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, compare with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        reading_t want;
        out_stall <= ($urandom_range(99) < rx_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading: position %0d plausible %0b", position, plausible);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    error_count++;
                end
                if (plausible !== want.plausible)
                begin
                    $error("plausible: expected %0b, got %0b", want.plausible, plausible);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side and register access
    // ------------------------------------------------------------------------

    // one sample request; valid is left high, an idle gap in the next call or a drain lowers it
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        predict_reading(s);
    endtask

    // stop requesting and wait for every outstanding reading
    task automatic drain_readings();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // one register write; the enable is lowered by the caller
    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // write the full register set while the block is idle
    task automatic program_filter(
        input logic [WCOUNT_W-1:0]    count,
        input logic [ALPHA_W-1:0]     alpha,
        input logic                   inv,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi
    );
        drain_readings();
        put_reg(REG_WINDOW_COUNT, CFG_W'(count));
        put_reg(REG_ALPHA,        CFG_W'(alpha));
        put_reg(REG_INVERT,       CFG_W'(inv));
        put_reg(REG_FAULT_LOW,    CFG_W'(lo));
        put_reg(REG_FAULT_HIGH,   CFG_W'(hi));
        cfg_we     <= 1'b0;
        cfg_count  = count;
        cfg_alpha  = alpha;
        cfg_invert = inv;
        cfg_low    = lo;
        cfg_high   = hi;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset register values: window of 5, alpha about 0.1, prime on zero
    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
    endtask

    // window count of zero acts as one, above the maximum as the maximum
    task automatic test_window_extremes();
        program_filter(5'd0, 17'd65536, 1'b0, 12'd0, 12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        program_filter(5'd31, 17'd65536, 1'b0, 12'd0, 12'd4095);
        send_sample(12'd1);
        send_sample(12'd4094);
        // even size picks the upper middle
        program_filter(5'd2, 17'd65536, 1'b0, 12'd0, 12'd4095);
        send_sample(12'd100);
        send_sample(12'd3000);
    endtask

    // alpha zero freezes the average; above unity overshoots into the clamps
    task automatic test_alpha_extremes();
        program_filter(5'd1, 17'd0, 1'b0, 12'd0, 12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        program_filter(5'd1, 17'h1FFFF, 1'b0, 12'd0, 12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
    endtask

    // mirrored output, crossed limits, single-point limits
    task automatic test_invert_and_limits();
        program_filter(5'd16, 17'd65536, 1'b1, 12'd3000, 12'd100);
        send_sample(12'd50);
        send_sample(12'd3500);
        program_filter(5'd3, 17'd65536, 1'b1, 12'd4095, 12'd4095);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd1);
    endtask

    // next sample for a given traffic shape
    function automatic logic [SAMPLE_BITS-1:0] next_sample(
        input int unsigned shape, input logic [SAMPLE_BITS-1:0] prev
    );
        int v;
        case (shape)
            0: v = $urandom_range(4095);
            // slow drift with noise
            1: v = int'(prev) + $urandom_range(64) - 32;
            // steady level with outliers, for the median
            2: v = ($urandom_range(4) == 0) ? $urandom_range(4095)
                                            : int'(prev) + $urandom_range(8) - 4;
            default: v = $urandom_range(1) ? 4095 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > CODE_MAX)
            v = CODE_MAX;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // random register settings, each followed by a burst of samples
    task automatic test_random_traffic(
        input int unsigned tx_pct, input int unsigned rx_pct, input int unsigned items
    );
        int unsigned            sent;
        int unsigned            burst;
        int unsigned            shape;
        logic [WCOUNT_W-1:0]    count;
        logic [ALPHA_W-1:0]     alpha;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] level;

        sent = 0;
        level = SAMPLE_BITS'($urandom_range(4095));
        while (sent < items)
        begin
            count = ($urandom_range(9) == 0) ? WCOUNT_W'($urandom_range(17, 31))
                                             : WCOUNT_W'($urandom_range(0, 16));
            case ($urandom_range(5))
                0:       alpha = 17'd0;
                1:       alpha = 17'd65536;
                2:       alpha = ALPHA_W'($urandom_range(65537, 131071));
                3:       alpha = ALPHA_W'($urandom_range(1, 4096));
                default: alpha = ALPHA_W'($urandom_range(1, 65535));
            endcase
            if ($urandom_range(3) == 0)
            begin
                lo = SAMPLE_BITS'($urandom_range(4095));
                hi = SAMPLE_BITS'($urandom_range(4095));
            end
            else
            begin
                lo = SAMPLE_BITS'($urandom_range(0, 2047));
                hi = SAMPLE_BITS'($urandom_range(2048, 4095));
            end
            program_filter(count, alpha, 1'($urandom_range(1)), lo, hi);

            // idle rates take effect for the traffic only
            tx_idle_pct  = tx_pct;
            rx_stall_pct = rx_pct;
            burst = $urandom_range(15, 40);
            shape = $urandom_range(3);
            for (int i = 0; i < burst && sent < items; i++)
            begin
                level = next_sample(shape, level);
                send_sample(level);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 33;
        rx_stall_pct = 80;
        test_reset_defaults();
        test_window_extremes();
        test_alpha_extremes();
        test_invert_and_limits();

        test_random_traffic(33, 80, 135);
        test_random_traffic(80, 33, 135);
        test_random_traffic(0, 0, 135);

        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/smef_pkg.sv
hw/rtl/smef_ram.sv
hw/rtl/smef_median.sv
hw/rtl/smef_ema.sv
hw/rtl/sensor_median_ema_filter.sv
hw/rtl/smef_checker.sv
bench/sensor_median_ema_filter_tb.sv
